[rtl/core/ffa_pkg.sv]
// Package for the first-fit allocator with oldest-first eviction.
// Holds the item structs, status codes and sequencer states.
// No dependencies.
`default_nettype none
package ffa_pkg;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_REJECTED = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPORT,
        S_FIND0,
        S_SCAN
    } t_state;

    typedef enum logic {
        K_ALLOC  = 1'b0,
        K_REPORT = 1'b1
    } t_kind;

    typedef struct packed {
        logic        kind;
        logic [15:0] length;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] start_res;
        logic [15:0] request_number;
        logic [5:0]  evicted_count;
        logic        last;
    } t_out;

endpackage
`default_nettype wire

[rtl/core/first_fit_fifo_evict_allocator.sv]
// A report gives one entry per cycle; the state register and the result register lie
// between start and the first entry. A reject is answered in the cycle after start;
// an allocate makes a search pass and repeats it after each eviction.
// One candidate gap start is tested per cycle against all live entries in parallel.
// A new item is taken the cycle busy falls. The receiver cannot stall.
// Synchronous active-low reset empties the table and restores space size 1024.
`default_nettype none
module first_fit_fifo_evict_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    input  ffa_pkg::t_in   i_item,
    output logic           busy,
    output logic           o_res_valid,
    output ffa_pkg::t_out  o_result,
    input  wire            i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire  [15:0]    i_cfg_data
);
    import ffa_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    // entries kept in age order, lane 0 oldest
    logic [15:0] r_bstart [MAX_BLOCKS];
    logic [15:0] r_bend   [MAX_BLOCKS];
    logic [15:0] r_bowner [MAX_BLOCKS];

    t_state      r_state, n_state;
    logic [15:0] r_space;
    logic [15:0] r_cnt;
    logic [CW-1:0] r_live;
    logic [15:0] r_len;
    logic [15:0] r_num;
    logic [5:0]  r_ev;
    logic [IW-1:0] r_k;
    logic [15:0] r_best;
    logic        r_best_ok;
    t_out        r_res;
    logic        r_res_valid;

    logic        w_accept;
    logic [16:0] w_cand;
    logic [17:0] w_cand_end;
    logic        w_fit;
    logic        w_last_k;
    logic        w_better;
    logic        w_full;
    logic [15:0] w_next_cnt;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;
    assign w_accept    = start && !busy;
    assign w_next_cnt  = r_cnt + 16'd1;
    assign w_full      = (r_live >= CW'(MAX_BLOCKS));
    assign w_last_k    = (CW'(r_k) == r_live - CW'(1));

    // candidate start and its fit test against every live lane
    always_comb begin
        logic ok;
        if (r_state == S_SCAN) begin
            w_cand = {1'b0, r_bend[r_k]} + 17'd1;
        end else begin
            w_cand = '0;
        end
        w_cand_end = {1'b0, w_cand} + {2'b00, r_len};
        ok = (w_cand_end <= {2'b00, r_space});
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (CW'(i) < r_live) begin
                if ({1'b0, r_bstart[i]} <= w_cand && w_cand <= {1'b0, r_bend[i]})
                    ok = 1'b0;
                if ({1'b0, r_bstart[i]} >= w_cand && {2'b00, r_bstart[i]} < w_cand_end)
                    ok = 1'b0;
            end
        end
        w_fit    = ok;
        w_better = w_fit && (!r_best_ok || w_cand[15:0] < r_best);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.kind == K_REPORT) begin
                        if (r_live != '0) n_state = S_REPORT;
                    end else if (i_item.length != 16'd0 && i_item.length <= r_space) begin
                        n_state = S_FIND0;
                    end
                end
            end
            S_REPORT: begin
                if (w_last_k) n_state = S_IDLE;
            end
            S_FIND0: begin
                if (w_fit) n_state = S_IDLE;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_last_k) begin
                    if (w_better || r_best_ok) n_state = S_IDLE;
                    else n_state = S_FIND0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control decisions taken this cycle
    logic        c_evict, c_place;
    logic [15:0] c_pos;
    always_comb begin
        c_evict = 1'b0;
        c_place = 1'b0;
        c_pos   = '0;
        unique case (r_state)
            S_IDLE: begin
                c_evict = w_accept && i_item.kind == K_ALLOC && i_item.length != 16'd0
                          && i_item.length <= r_space && w_full;
            end
            S_FIND0: begin
                c_place = w_fit;
            end
            S_SCAN: begin
                if (w_last_k) begin
                    c_place = w_better || r_best_ok;
                    c_evict = !(w_better || r_best_ok);
                    c_pos   = w_better ? w_cand[15:0] : r_best;
                end
            end
            S_REPORT: ;
            default: ;
        endcase
    end

    // a result goes out on a placement, a report entry, an empty report or a reject
    logic w_res_fire;
    assign w_res_fire = c_place || (r_state == S_REPORT) ||
                        (r_state == S_IDLE && w_accept &&
                         ((i_item.kind == K_REPORT) ? (r_live == '0) :
                          (i_item.length == 16'd0 || i_item.length > r_space)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_space     <= 16'd1024;
            r_cnt       <= '0;
            r_live      <= '0;
            r_res_valid <= 1'b0;
            r_best_ok   <= 1'b0;
            r_k         <= '0;
            r_ev        <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= w_res_fire;
            if (i_cfg_valid) r_space <= i_cfg_data;

            if (c_evict) begin
                for (int i = 0; i < MAX_BLOCKS - 1; i++) begin
                    r_bstart[i] <= r_bstart[i+1];
                    r_bend[i]   <= r_bend[i+1];
                    r_bowner[i] <= r_bowner[i+1];
                end
                r_live <= r_live - CW'(1);
            end

            if (c_place) begin
                r_bstart[r_live[IW-1:0]] <= c_pos;
                r_bend[r_live[IW-1:0]]   <= c_pos + r_len - 16'd1;
                r_bowner[r_live[IW-1:0]] <= r_num;
                r_live                   <= r_live + CW'(1);
                r_res.status             <= ST_PLACED;
                r_res.start_res          <= c_pos;
                r_res.request_number     <= r_num;
                r_res.evicted_count      <= r_ev;
                r_res.last               <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_k       <= '0;
                    r_best_ok <= 1'b0;
                    if (w_accept) begin
                        r_len <= i_item.length;
                        if (i_item.kind == K_REPORT) begin
                            if (r_live == '0) begin
                                r_res.status         <= ST_EMPTY;
                                r_res.start_res      <= '0;
                                r_res.request_number <= '0;
                                r_res.evicted_count  <= '0;
                                r_res.last           <= 1'b1;
                            end
                        end else begin
                            r_cnt <= w_next_cnt;
                            r_num <= w_next_cnt;
                            r_ev  <= c_evict ? 6'd1 : 6'd0;
                            if (i_item.length == 16'd0 || i_item.length > r_space) begin
                                r_res.status         <= ST_REJECTED;
                                r_res.start_res      <= '0;
                                r_res.request_number <= w_next_cnt;
                                r_res.evicted_count  <= '0;
                                r_res.last           <= 1'b1;
                            end
                        end
                    end
                end
                S_REPORT: begin
                    r_res.status         <= ST_ENTRY;
                    r_res.start_res      <= r_bstart[r_k];
                    r_res.request_number <= r_bowner[r_k];
                    r_res.evicted_count  <= '0;
                    r_res.last           <= w_last_k;
                    r_k                  <= r_k + IW'(1);
                end
                S_FIND0: begin
                    r_k       <= '0;
                    r_best_ok <= 1'b0;
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_best    <= w_cand[15:0];
                        r_best_ok <= 1'b1;
                    end
                    r_k <= r_k + IW'(1);
                    if (c_evict) r_ev <= r_ev + 6'd1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(MAX_BLOCKS))
        else $error("table holds more entries than it has lanes");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.last |-> !busy)
        else $error("final result shown while still busy");

    a_place_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.status == ST_PLACED |-> r_live != '0)
        else $error("placement left the table empty");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_live != '0)
        else $error("gap scan entered with an empty table");
`endif

endmodule
`default_nettype wire
